@@ hw/rtl/qspp_pkg.sv @@
// ----------------------------------------------------------------------------
// Quadrature speed PID PWM package
// Shared widths, constants, register indexes, decode helper and the request
// type of the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package qspp_pkg;

  // Pulse counter, integral accumulator and speed formats.
  localparam int COUNT_BITS = 16;
  localparam int SUM_BITS   = 24;
  localparam int SPEED_FRAC = 12;
  localparam int SPEED_W    = 16;
  localparam int GAIN_FRAC  = 8;
  localparam int DER_W      = 20;

  // Shared multiplier: signed operands, full-width signed product.
  // The operand width covers the widest PID quantity (the control sum).
  localparam int MUL_W  = 28;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = MUL_W;
  localparam int DX_W   = 27;

  // Floor division by five through a reciprocal multiply and a correction.
  localparam int DIV5_SHIFT = 28;
  localparam logic [MUL_W-1:0] DIV5_MULT = MUL_W'((64'd1 << DIV5_SHIFT) / 5);

  // PWM mapping.
  localparam int PWM_SHIFT = SPEED_FRAC + GAIN_FRAC;
  localparam logic [7:0] DEAD_ZONE = 8'd15;
  localparam logic [7:0] DUTY_MAX  = 8'd255;

  // Stream payload widths.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Configuration port.
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_TO_SPEED = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SPEED     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_OFFSET     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_SCALE      = 4'd7;

  // Register values after reset.
  localparam logic [15:0] INTEGRAL_LIMIT_RST = 16'd1229;
  localparam logic [15:0] STOP_SPEED_RST     = 16'd287;
  localparam logic [15:0] PWM_OFFSET_RST     = 16'd2376;
  localparam logic [15:0] PWM_SCALE_RST      = 16'd4211;

  // Count direction of one decoded phase step.
  localparam logic [1:0] DIR_HOLD = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // One input item as it sits in tdata, lowest field at bit 0.
  typedef struct packed {
    logic [15:0] target_speed;
    logic        pid_tick;
    logic        window_end;
    logic        enc_b;
    logic        enc_a;
  } in_item_t;

  // Operand pair for the shared multiplier.
  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  // Decode a quadrature step; phases are {A, B}. No change and a double
  // change both hold the count.
  function automatic logic [1:0] quad_dir(input logic [1:0] last, input logic [1:0] now);
    logic [3:0] code;
    logic [1:0] dir;
    code = {last, now};
    dir  = DIR_HOLD;
    if (code inside {4'b0001, 4'b0111, 4'b1110, 4'b1000}) begin
      dir = DIR_DOWN;
    end else if (code inside {4'b0010, 4'b1011, 4'b1101, 4'b0100}) begin
      dir = DIR_UP;
    end
    return dir;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/qspp_mul.sv @@
// ----------------------------------------------------------------------------
// Quadrature speed PID PWM shared multiplier
// Signed multiplier with a registered product, shared by every multiply step of the
// speed and PID sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module qspp_mul (
  input  wire logic                                  clk,
  input  wire qspp_pkg::mul_req_t                    req,
  output logic signed [qspp_pkg::PROD_W-1:0]         prod
);

  // The product is registered and lands in the cycle after the operands are presented.
  always_ff @(posedge clk) begin
    prod <= req.a * req.b;
  end

endmodule

`default_nettype wire

@@ hw/rtl/quadrature_speed_pid_pwm.sv @@
// Each accepted item is decoded and its result registered; window_end adds one multiplier
// pass (the speed latch) and pid_tick adds five passes (the PID step and PWM mapping).
// No new item is taken until the sequencer, walking its steps through the single shared
// multiplier, has handed its result to the output register and returned to idle.
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous, active high) clears control and block state, loads register defaults.
// ----------------------------------------------------------------------------
// Quadrature speed PID PWM
// Decodes encoder phases into a saturating pulse count, converts the count
// to speed at each window end and runs a PID step with PWM mapping on each
// PID tick, all multiplies through one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_speed_pid_pwm (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input stream.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // enc_a[0], enc_b[1], window_end[2], pid_tick[3], target_speed[19:4], zero[23:20]
  input  wire logic [qspp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // Result stream.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // pwm_duty[7:0], speed_now[23:8], pulse_total[39:24]
  output logic [qspp_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // Configuration writes.
  input  wire logic                                cfg_we,
  input  wire logic [qspp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [qspp_pkg::CFG_W-1:0]          cfg_data
);

  localparam int CB = qspp_pkg::COUNT_BITS;
  localparam int SB = qspp_pkg::SUM_BITS;
  localparam int DX = qspp_pkg::DX_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_WMUL = 4'd2;
  localparam logic [3:0] S_WEND = 4'd3;
  localparam logic [3:0] S_ERR  = 4'd4;
  localparam logic [3:0] S_MP   = 4'd5;
  localparam logic [3:0] S_MI   = 4'd6;
  localparam logic [3:0] S_MD   = 4'd7;
  localparam logic [3:0] S_DSUM = 4'd8;
  localparam logic [3:0] S_MDIV = 4'd9;
  localparam logic [3:0] S_DCOR = 4'd10;
  localparam logic [3:0] S_CTL  = 4'd11;
  localparam logic [3:0] S_MPWM = 4'd12;
  localparam logic [3:0] S_PWM  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  // Saturation bounds.
  localparam logic signed [CB-1:0] CNT_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CNT_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] CNT_ONE = CB'(1);
  localparam logic signed [SB:0]   SUM_MAX = {2'b00, {(SB-1){1'b1}}};
  localparam logic signed [SB:0]   SUM_MIN = {2'b11, {(SB-1){1'b0}}};
  localparam logic signed [DX-1:0] DER_MAX =
    {{(DX-qspp_pkg::DER_W+1){1'b0}}, {(qspp_pkg::DER_W-1){1'b1}}};
  localparam logic signed [DX-1:0] DER_MIN =
    {{(DX-qspp_pkg::DER_W+1){1'b1}}, {(qspp_pkg::DER_W-1){1'b0}}};
  localparam logic signed [DX-1:0] DX_ONE  = DX'(1);
  localparam logic signed [DX-1:0] DX_FIVE = DX'(5);
  localparam logic signed [32:0]   PT_MAX  = 33'sd32767;
  localparam logic signed [32:0]   PT_MIN  = -33'sd32768;

  // Sequencer and handshake registers.
  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid;
  logic       slot_free;
  qspp_pkg::in_item_t in_reg;
  logic [qspp_pkg::OUT_DATA_W-1:0] out_data;

  // Configuration registers.
  logic [11:0] count_to_speed;
  logic [15:0] gain_p;
  logic [15:0] gain_i;
  logic [15:0] gain_d;
  logic [15:0] integral_limit;
  logic [15:0] stop_speed;
  logic [15:0] pwm_offset;
  logic [15:0] pwm_scale;

  // Block state.
  logic [1:0]                      last_phase;
  logic signed [CB-1:0]            window_count;
  logic [15:0]                     measured_speed;
  logic [15:0]                     earlier_speed;
  logic signed [SB-1:0]            error_sum;
  logic signed [qspp_pkg::DER_W-1:0] smoothed_derivative;
  logic [7:0]                      drive_value;

  // PID working registers.
  logic signed [16:0]              err;
  logic signed [qspp_pkg::ACC_W-1:0] acc;
  logic signed [DX-1:0]            dx;

  // Shared multiplier.
  qspp_pkg::mul_req_t              mul_req;
  logic signed [qspp_pkg::PROD_W-1:0] prod;
  logic signed [qspp_pkg::PROD_W-1:0] prod_gain;

  // Combinational helpers.
  logic [1:0]                      dir;
  logic signed [CB-1:0]            count_next;
  logic [CB-1:0]                   count_mag;
  logic [15:0]                     speed_sat;
  logic signed [16:0]              err_now;
  logic signed [16:0]              speed_diff;
  logic signed [SB:0]              sum_wide;
  logic signed [SB-1:0]            sum_sat;
  logic signed [qspp_pkg::PROD_W-1:0] lim_pos;
  logic signed [qspp_pkg::PROD_W-1:0] i_term;
  logic signed [DX-1:0]            q0;
  logic signed [DX-1:0]            rem;
  logic signed [DX-1:0]            q_fix;
  logic signed [DX-1:0]            der_sat;
  logic [qspp_pkg::PROD_W-1:0]     pwm_wide;
  logic [7:0]                      duty;
  logic signed [32:0]              wc_wide;
  logic [15:0]                     pulse16;

  qspp_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign slot_free     = !out_valid || m_axis_tready;

  // Phase decode and saturating pulse count.
  assign dir = qspp_pkg::quad_dir(last_phase, {in_reg.enc_a, in_reg.enc_b});

  always_comb begin
    count_next = window_count;
    if (dir == qspp_pkg::DIR_UP && window_count != CNT_MAX) begin
      count_next = window_count + CNT_ONE;
    end else if (dir == qspp_pkg::DIR_DOWN && window_count != CNT_MIN) begin
      count_next = window_count - CNT_ONE;
    end
  end

  assign count_mag = window_count[CB-1] ? unsigned'(-window_count) : unsigned'(window_count);

  // Speed from the registered product, saturated to the speed range.
  assign speed_sat = (|prod[qspp_pkg::PROD_W-1:qspp_pkg::SPEED_W]) ? 16'hFFFF :
                     prod[qspp_pkg::SPEED_W-1:0];

  // Speed error and error accumulation with standstill clear.
  assign err_now    = $signed({1'b0, in_reg.target_speed}) - $signed({1'b0, measured_speed});
  assign speed_diff = $signed({1'b0, earlier_speed}) - $signed({1'b0, measured_speed});
  assign sum_wide   = (SB+1)'(error_sum) + (SB+1)'(err_now);

  always_comb begin
    if (sum_wide > SUM_MAX) begin
      sum_sat = SB'(SUM_MAX);
    end else if (sum_wide < SUM_MIN) begin
      sum_sat = SB'(SUM_MIN);
    end else begin
      sum_sat = SB'(sum_wide);
    end
  end

  // Gains are Q8.8, so gain products carry eight fraction bits; the arithmetic shift gives the floor.
  assign prod_gain = prod >>> qspp_pkg::GAIN_FRAC;

  // Integral term clamp.
  assign lim_pos = $signed(qspp_pkg::PROD_W'(integral_limit));

  always_comb begin
    if (prod_gain > lim_pos) begin
      i_term = lim_pos;
    end else if (prod_gain < -lim_pos) begin
      i_term = -lim_pos;
    end else begin
      i_term = prod_gain;
    end
  end

  // Floor division by five: reciprocal estimate, then one correction.
  assign q0  = DX'(prod >>> qspp_pkg::DIV5_SHIFT);
  assign rem = dx - (q0 <<< 2) - q0;

  always_comb begin
    if (rem < 0) begin
      q_fix = q0 - DX_ONE;
    end else if (rem >= DX_FIVE) begin
      q_fix = q0 + DX_ONE;
    end else begin
      q_fix = q0;
    end
    if (q_fix > DER_MAX) begin
      der_sat = DER_MAX;
    end else if (q_fix < DER_MIN) begin
      der_sat = DER_MIN;
    end else begin
      der_sat = q_fix;
    end
  end

  // PWM mapping with dead zone and upper clamp.
  assign pwm_wide = unsigned'(prod >>> qspp_pkg::PWM_SHIFT);

  always_comb begin
    if (acc <= 0) begin
      duty = 8'd0;
    end else if (|pwm_wide[qspp_pkg::PROD_W-1:8]) begin
      duty = qspp_pkg::DUTY_MAX;
    end else if (pwm_wide[7:0] <= qspp_pkg::DEAD_ZONE) begin
      duty = 8'd0;
    end else begin
      duty = pwm_wide[7:0];
    end
  end

  // Reported pulse count, clamped to 16 bits.
  assign wc_wide = 33'(window_count);
  assign pulse16 = (wc_wide > PT_MAX) ? 16'h7FFF :
                   (wc_wide < PT_MIN) ? 16'h8000 : wc_wide[15:0];

  // Multiplier operand selection per sequencer step.
  always_comb begin
    mul_req.a = '0;
    mul_req.b = '0;
    case (state)
      S_WMUL: begin
        mul_req.a = $signed(qspp_pkg::MUL_W'(count_mag));
        mul_req.b = $signed(qspp_pkg::MUL_W'(count_to_speed));
      end
      S_MP: begin
        mul_req.a = qspp_pkg::MUL_W'(err);
        mul_req.b = $signed(qspp_pkg::MUL_W'(gain_p));
      end
      S_MI: begin
        mul_req.a = qspp_pkg::MUL_W'(error_sum);
        mul_req.b = $signed(qspp_pkg::MUL_W'(gain_i));
      end
      S_MD: begin
        mul_req.a = qspp_pkg::MUL_W'(speed_diff);
        mul_req.b = $signed(qspp_pkg::MUL_W'(gain_d));
      end
      S_MDIV: begin
        mul_req.a = qspp_pkg::MUL_W'(dx);
        mul_req.b = $signed(qspp_pkg::DIV5_MULT);
      end
      S_MPWM: begin
        mul_req.a = acc;
        mul_req.b = $signed(qspp_pkg::MUL_W'(pwm_scale));
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (in_reg.window_end) begin
          state_next = S_WMUL;
        end else if (in_reg.pid_tick) begin
          state_next = S_ERR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WMUL: state_next = S_WEND;
      S_WEND: state_next = in_reg.pid_tick ? S_ERR : S_DONE;
      S_ERR:  state_next = S_MP;
      S_MP:   state_next = S_MI;
      S_MI:   state_next = S_MD;
      S_MD:   state_next = S_DSUM;
      S_DSUM: state_next = S_MDIV;
      S_MDIV: state_next = S_DCOR;
      S_DCOR: state_next = S_CTL;
      S_CTL:  state_next = S_MPWM;
      S_MPWM: state_next = S_PWM;
      S_PWM:  state_next = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer and result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input latch and result register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      in_reg <= qspp_pkg::in_item_t'(s_axis_tdata[$bits(qspp_pkg::in_item_t)-1:0]);
    end
    if (state == S_DONE && slot_free) begin
      out_data <= {pulse16, measured_speed, drive_value};
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_to_speed <= '0;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_limit <= qspp_pkg::INTEGRAL_LIMIT_RST;
      stop_speed     <= qspp_pkg::STOP_SPEED_RST;
      pwm_offset     <= qspp_pkg::PWM_OFFSET_RST;
      pwm_scale      <= qspp_pkg::PWM_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        qspp_pkg::REG_COUNT_TO_SPEED: count_to_speed <= cfg_data[11:0];
        qspp_pkg::REG_GAIN_P:         gain_p         <= cfg_data;
        qspp_pkg::REG_GAIN_I:         gain_i         <= cfg_data;
        qspp_pkg::REG_GAIN_D:         gain_d         <= cfg_data;
        qspp_pkg::REG_INTEGRAL_LIMIT: integral_limit <= cfg_data;
        qspp_pkg::REG_STOP_SPEED:     stop_speed     <= cfg_data;
        qspp_pkg::REG_PWM_OFFSET:     pwm_offset     <= cfg_data;
        qspp_pkg::REG_PWM_SCALE:      pwm_scale      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Measurement and control state, updated step by step.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase          <= '0;
      window_count        <= '0;
      measured_speed      <= '0;
      earlier_speed       <= '0;
      error_sum           <= '0;
      smoothed_derivative <= '0;
      drive_value         <= '0;
    end else begin
      case (state)
        S_DEC: begin
          window_count <= count_next;
          last_phase   <= {in_reg.enc_a, in_reg.enc_b};
        end
        S_WEND: begin
          measured_speed <= speed_sat;
          window_count   <= '0;
        end
        S_ERR: begin
          error_sum <= (measured_speed <= stop_speed) ? '0 : sum_sat;
        end
        S_DCOR: begin
          smoothed_derivative <= qspp_pkg::DER_W'(der_sat);
        end
        S_PWM: begin
          drive_value   <= duty;
          earlier_speed <= measured_speed;
        end
        default: ;
      endcase
    end
  end

  // PID working registers (payload, no reset).
  always_ff @(posedge clk) begin
    case (state)
      S_ERR: err <= err_now;
      S_MI: begin
        // Current speed plus the proportional term.
        acc <= qspp_pkg::ACC_W'($signed({1'b0, measured_speed}))
             + qspp_pkg::ACC_W'(prod_gain);
      end
      S_MD: acc <= acc + qspp_pkg::ACC_W'(i_term);
      S_DSUM: begin
        // Four times the old derivative plus the raw derivative.
        dx <= (DX'(smoothed_derivative) <<< 2) + DX'(prod_gain);
      end
      S_CTL: begin
        acc <= acc + qspp_pkg::ACC_W'(smoothed_derivative)
             + $signed(qspp_pkg::ACC_W'(pwm_offset));
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/qspp_checker.sv @@
// ----------------------------------------------------------------------------
// Quadrature speed PID PWM port checker
// Watches the top-level ports for handshake and result properties; bound
// to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qspp_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [qspp_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The block works on one item at a time.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

  // A result never shows up on the edge right after an acceptance.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared too early");

  // Duty is either zero or above the dead zone.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0) || (m_axis_tdata[7:0] > qspp_pkg::DEAD_ZONE))
    else $error("duty inside dead zone");

endmodule

bind quadrature_speed_pid_pwm qspp_checker u_qspp_checker (.*);

`default_nettype wire

@@ tb/tb_quadrature_speed_pid_pwm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature speed PID PWM testbench
// Streams encoder samples with window and PID ticks into the block and checks
// every status transaction against a typed status or a cycle-free model of the
// decoder, speed latch, PID loop and PWM mapping. A short table of directed
// steps runs first, then a spin that runs the pulse count far up and down and
// saturates the speed, then randomized phases under several register settings.
// ----------------------------------------------------------------------------

module tb_quadrature_speed_pid_pwm;

  localparam int NUM_REGS      = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int SPIN_STEPS    = 200;
  localparam int MAX_REPORTS   = 10;
  localparam logic [15:0] C2S_MASK = 16'h0FFF;

  localparam longint CNT_MAX = (longint'(1) << (qspp_pkg::COUNT_BITS - 1)) - 1;
  localparam longint SUM_MAX = (longint'(1) << (qspp_pkg::SUM_BITS - 1)) - 1;
  localparam longint DER_MAX = (longint'(1) << (qspp_pkg::DER_W - 1)) - 1;

  // One status transaction, laid out as it sits in m_axis_tdata.
  typedef struct packed {
    logic signed [15:0] pulse_total;
    logic [15:0]        speed_now;
    logic [7:0]         pwm_duty;
  } status_t;

  // One directed step with an optional hand-written status.
  typedef struct packed {
    qspp_pkg::in_item_t item;
    logic               typed;
    status_t            want;
  } step_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [qspp_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [qspp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            cfg_we = 1'b0;
  logic [qspp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [qspp_pkg::CFG_W-1:0]      cfg_data = '0;

  // Model state and register copies.
  logic [1:0]  mdl_phase;
  longint      mdl_count;
  longint      mdl_speed;
  longint      mdl_prev_speed;
  longint      mdl_err_sum;
  longint      mdl_deriv;
  logic [7:0]  mdl_duty;
  longint      mdl_reg [NUM_REGS];

  status_t     expected_status [$];
  int          mismatch_count = 0;
  bit          steady_flow = 1'b0;
  logic [1:0]  sent_phase = 2'b00;
  bit          spin_up = 1'b1;
  status_t     got_status;
  status_t     want_status;

  // Directed steps. Columns: {target, pid, window, B, A}, typed, {pulse, speed, duty}.
  step_row_t directed_rows [19] = '{
    '{'{16'd0,     1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{16'sd0,  16'd0, 8'd0}},
    '{'{16'd0,     1'b0, 1'b0, 1'b1, 1'b0}, 1'b1, '{-16'sd1, 16'd0, 8'd0}},
    '{'{16'd0,     1'b0, 1'b0, 1'b1, 1'b1}, 1'b1, '{-16'sd2, 16'd0, 8'd0}},
    '{'{16'd0,     1'b0, 1'b0, 1'b0, 1'b1}, 1'b1, '{-16'sd3, 16'd0, 8'd0}},
    '{'{16'd0,     1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{-16'sd4, 16'd0, 8'd0}},
    '{'{16'd0,     1'b0, 1'b0, 1'b0, 1'b1}, 1'b1, '{-16'sd3, 16'd0, 8'd0}},
    '{'{16'd0,     1'b0, 1'b0, 1'b1, 1'b1}, 1'b1, '{-16'sd2, 16'd0, 8'd0}},
    '{'{16'd0,     1'b0, 1'b0, 1'b1, 1'b0}, 1'b1, '{-16'sd1, 16'd0, 8'd0}},
    '{'{16'd0,     1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{16'sd0,  16'd0, 8'd0}},
    '{'{16'd0,     1'b0, 1'b0, 1'b1, 1'b1}, 1'b1, '{16'sd0,  16'd0, 8'd0}},
    '{'{16'd0,     1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{16'sd0,  16'd0, 8'd0}},
    '{'{16'd0,     1'b0, 1'b0, 1'b1, 1'b0}, 1'b1, '{-16'sd1, 16'd0, 8'd0}},
    '{'{16'd0,     1'b0, 1'b0, 1'b0, 1'b1}, 1'b1, '{-16'sd1, 16'd0, 8'd0}},
    '{'{16'd0,     1'b0, 1'b1, 1'b0, 1'b1}, 1'b1, '{16'sd0,  16'd0, 8'd0}},
    '{'{16'hFFFF,  1'b1, 1'b0, 1'b1, 1'b1}, 1'b1, '{16'sd1,  16'd0, 8'd0}},
    '{'{16'd0,     1'b1, 1'b1, 1'b1, 1'b0}, 1'b1, '{16'sd0,  16'd0, 8'd0}},
    '{'{16'hFFFF,  1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, '{16'sd0,  16'd0, 8'd0}},
    '{'{16'hFFFF,  1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '{16'sd0,  16'd0, 8'd0}},
    '{'{16'h5A5A,  1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '{16'sd0,  16'd0, 8'd0}}
  };

  quadrature_speed_pid_pwm DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Division by five rounded toward minus infinity.
  function automatic longint div5_floor(input longint x);
    if (x >= 0) begin
      return x / 5;
    end
    return -((-x + 4) / 5);
  endfunction

  // Next Gray step of the encoder, {A, B}, in either direction.
  function automatic logic [1:0] quad_next(input logic [1:0] ph, input bit up);
    case (ph)
      2'b00:   return up ? 2'b10 : 2'b01;
      2'b10:   return up ? 2'b11 : 2'b00;
      2'b11:   return up ? 2'b01 : 2'b10;
      default: return up ? 2'b00 : 2'b11;
    endcase
  endfunction

  task automatic reset_motor_model();
    mdl_phase      = 2'b00;
    mdl_count      = 0;
    mdl_speed      = 0;
    mdl_prev_speed = 0;
    mdl_err_sum    = 0;
    mdl_deriv      = 0;
    mdl_duty       = 8'd0;
    foreach (mdl_reg[k]) mdl_reg[k] = 0;
    mdl_reg[qspp_pkg::REG_INTEGRAL_LIMIT] = qspp_pkg::INTEGRAL_LIMIT_RST;
    mdl_reg[qspp_pkg::REG_STOP_SPEED]     = qspp_pkg::STOP_SPEED_RST;
    mdl_reg[qspp_pkg::REG_PWM_OFFSET]     = qspp_pkg::PWM_OFFSET_RST;
    mdl_reg[qspp_pkg::REG_PWM_SCALE]      = qspp_pkg::PWM_SCALE_RST;
  endtask

  // Decode, window latch, PID update and PWM mapping for one accepted sample.
  function automatic status_t advance_motor_model(input qspp_pkg::in_item_t it);
    logic [1:0] now;
    logic [3:0] code;
    longint     err, p_term, i_term, d_raw, ctl, sum, lim, v, mag, pulse;
    status_t    s;
    now  = {it.enc_a, it.enc_b};
    code = {mdl_phase, now};
    case (code)
      4'b0001, 4'b0111, 4'b1110, 4'b1000:
        mdl_count = clamp(mdl_count - 1, -CNT_MAX - 1, CNT_MAX);
      4'b0010, 4'b1011, 4'b1101, 4'b0100:
        mdl_count = clamp(mdl_count + 1, -CNT_MAX - 1, CNT_MAX);
      default: ;
    endcase
    mdl_phase = now;

    if (it.window_end) begin
      mag       = (mdl_count < 0) ? -mdl_count : mdl_count;
      mdl_speed = clamp(mag * mdl_reg[qspp_pkg::REG_COUNT_TO_SPEED], 0, 65535);
      mdl_count = 0;
    end

    if (it.pid_tick) begin
      lim         = mdl_reg[qspp_pkg::REG_INTEGRAL_LIMIT];
      err         = longint'(it.target_speed) - mdl_speed;
      mdl_err_sum = clamp(mdl_err_sum + err, -SUM_MAX - 1, SUM_MAX);
      if (mdl_speed <= mdl_reg[qspp_pkg::REG_STOP_SPEED]) begin
        mdl_err_sum = 0;
      end
      p_term    = (mdl_reg[qspp_pkg::REG_GAIN_P] * err) >>> qspp_pkg::GAIN_FRAC;
      i_term    = clamp((mdl_reg[qspp_pkg::REG_GAIN_I] * mdl_err_sum) >>> qspp_pkg::GAIN_FRAC,
                        -lim, lim);
      d_raw     = (mdl_reg[qspp_pkg::REG_GAIN_D] * (mdl_prev_speed - mdl_speed))
                  >>> qspp_pkg::GAIN_FRAC;
      mdl_deriv = clamp(div5_floor(4 * mdl_deriv + d_raw), -DER_MAX - 1, DER_MAX);
      ctl       = mdl_speed + p_term + i_term + mdl_deriv;
      sum       = ctl + mdl_reg[qspp_pkg::REG_PWM_OFFSET];
      if (sum <= 0) begin
        mdl_duty = 8'd0;
      end else begin
        v = (sum * mdl_reg[qspp_pkg::REG_PWM_SCALE]) >>> qspp_pkg::PWM_SHIFT;
        if (v <= qspp_pkg::DEAD_ZONE) begin
          mdl_duty = 8'd0;
        end else if (v > qspp_pkg::DUTY_MAX) begin
          mdl_duty = qspp_pkg::DUTY_MAX;
        end else begin
          mdl_duty = v[7:0];
        end
      end
      mdl_prev_speed = mdl_speed;
    end

    pulse         = clamp(mdl_count, -32768, 32767);
    s.pwm_duty    = mdl_duty;
    s.speed_now   = mdl_speed[15:0];
    s.pulse_total = pulse[15:0];
    return s;
  endfunction

  // Present one sample, wait for its transaction and record the expected status.
  task automatic send_item(input qspp_pkg::in_item_t it, input bit typed,
                           input status_t typed_want);
    status_t want;
    while (!steady_flow && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= qspp_pkg::IN_DATA_W'(it);
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    want       = advance_motor_model(it);
    sent_phase = {it.enc_a, it.enc_b};
    expected_status.push_back(typed ? typed_want : want);
  endtask

  // Stop sending, then wait for every outstanding status and let the block settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [qspp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qspp_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == qspp_pkg::REG_COUNT_TO_SPEED) begin
      mdl_reg[idx] = val & C2S_MASK;
    end else if (idx < NUM_REGS) begin
      mdl_reg[idx] = val;
    end
  endtask

  // Load the register setting of one phase, plus a write to an unused index.
  task automatic apply_setting(input int p);
    logic [qspp_pkg::CFG_W-1:0] val [NUM_REGS];
    foreach (val[k]) val[k] = 16'($urandom);
    case (p)
      0: foreach (val[k]) val[k] = 16'hFFFF;
      1: foreach (val[k]) val[k] = 16'h0000;
      2: begin
        val[qspp_pkg::REG_COUNT_TO_SPEED] = 16'd200;
        val[qspp_pkg::REG_GAIN_P]         = 16'd512;
        val[qspp_pkg::REG_GAIN_I]         = 16'd64;
        val[qspp_pkg::REG_GAIN_D]         = 16'd32;
        val[qspp_pkg::REG_INTEGRAL_LIMIT] = qspp_pkg::INTEGRAL_LIMIT_RST;
        val[qspp_pkg::REG_STOP_SPEED]     = qspp_pkg::STOP_SPEED_RST;
        val[qspp_pkg::REG_PWM_OFFSET]     = qspp_pkg::PWM_OFFSET_RST;
        val[qspp_pkg::REG_PWM_SCALE]      = qspp_pkg::PWM_SCALE_RST;
      end
      3: begin
        // Strong integral with the standstill clear only at zero speed, to push the error sum to its limits.
        val[qspp_pkg::REG_COUNT_TO_SPEED] = 16'd300;
        val[qspp_pkg::REG_GAIN_P]         = 16'd256;
        val[qspp_pkg::REG_GAIN_I]         = 16'hFFFF;
        val[qspp_pkg::REG_GAIN_D]         = 16'hFFFF;
        val[qspp_pkg::REG_INTEGRAL_LIMIT] = 16'hFFFF;
        val[qspp_pkg::REG_STOP_SPEED]     = 16'd0;
        val[qspp_pkg::REG_PWM_OFFSET]     = 16'd0;
      end
      default: ;
    endcase
    for (int k = 0; k < NUM_REGS; k++) begin
      write_reg(qspp_pkg::CFG_IDX_W'(k), val[k]);
    end
    write_reg(qspp_pkg::CFG_IDX_W'(NUM_REGS + $urandom_range(0, 7)), 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Mostly clean quadrature runs with random ticks and targets, some noise.
  function automatic qspp_pkg::in_item_t random_item();
    qspp_pkg::in_item_t it;
    int                 pick;
    if ($urandom_range(0, 99) < 5) spin_up = ~spin_up;
    if ($urandom_range(0, 99) < 85) begin
      {it.enc_a, it.enc_b} = ($urandom_range(0, 99) < 70) ? quad_next(sent_phase, spin_up)
                                                           : sent_phase;
    end else begin
      {it.enc_a, it.enc_b} = 2'($urandom);
    end
    it.window_end = ($urandom_range(0, 99) < 12);
    it.pid_tick   = it.window_end ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 99) < 15);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      it.target_speed = 16'd0;
    end else if (pick < 20) begin
      it.target_speed = 16'hFFFF;
    end else if (pick < 60) begin
      it.target_speed = 16'($urandom_range(0, 4000));
    end else begin
      it.target_speed = 16'($urandom);
    end
    return it;
  endfunction

  // Turn the encoder a long way in one direction with no ticks.
  task automatic spin(input bit up, input int steps);
    qspp_pkg::in_item_t it;
    it = '0;
    for (int n = 0; n < steps; n++) begin
      {it.enc_a, it.enc_b} = quad_next(sent_phase, up);
      send_item(it, 1'b0, '0);
    end
  endtask

  // Result side: random back-pressure and comparison of every transaction.
  always @(posedge clk) begin
    m_axis_tready <= rst ? 1'b0 : (steady_flow || $urandom_range(0, 99) >= 8);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_status = status_t'(m_axis_tdata);
      if (expected_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("status with nothing expected: duty %0d speed %0d pulse %0d",
                   got_status.pwm_duty, got_status.speed_now, got_status.pulse_total);
        end
      end else begin
        want_status = expected_status.pop_front();
        if (got_status.pwm_duty !== want_status.pwm_duty ||
            got_status.speed_now !== want_status.speed_now ||
            got_status.pulse_total !== want_status.pulse_total) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: duty %0d/%0d speed %0d/%0d pulse %0d/%0d (exp/act)",
                     $realtime, want_status.pwm_duty, got_status.pwm_duty,
                     want_status.speed_now, got_status.speed_now,
                     want_status.pulse_total, got_status.pulse_total);
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin
    qspp_pkg::in_item_t it;
    reset_motor_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed steps under the reset register values.
    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
    end
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      apply_setting(p);
      steady_flow = (p == 2);
      if (p == 0) begin
        // Run the count far upward, latch a saturated speed, then run it downward.
        spin(1'b1, SPIN_STEPS);
        it = '0;
        {it.enc_a, it.enc_b} = sent_phase;
        it.window_end   = 1'b1;
        it.pid_tick     = 1'b1;
        it.target_speed = 16'($urandom);
        send_item(it, 1'b0, '0);
        spin(1'b0, SPIN_STEPS);
        it.pid_tick = 1'b0;
        {it.enc_a, it.enc_b} = sent_phase;
        send_item(it, 1'b0, '0);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(random_item(), 1'b0, '0);
      end
      drain_results();
    end

    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #100_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/qspp_pkg.sv
hw/rtl/qspp_mul.sv
hw/rtl/quadrature_speed_pid_pwm.sv
hw/rtl/qspp_checker.sv
tb/tb_quadrature_speed_pid_pwm.sv
